// ===== hw/rtl/mvrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvrm_pkg
// Shared types and constants of the multi-voice ring mixer: beat payloads,
// request modes, register map and controller states.
// ----------------------------------------------------------------------------
package mvrm_pkg;

   // request modes
   localparam logic [1:0] MODE_WRITE   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_TICK    = 2'd2;
   localparam logic [1:0] MODE_MIX     = 2'd3;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_ENABLE   = 2'd0;
   localparam logic [1:0] REG_PR_FRAMES = 2'd1;
   localparam logic [1:0] REG_PR_TIMEOUT = 2'd2;

   // register reset values
   localparam logic [15:0] PR_FRAMES_RST  = 16'd2048;
   localparam logic [7:0]  PR_TIMEOUT_RST = 8'd10;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FRAME  = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        owner;
      logic signed [15:0] left_in;
      logic signed [15:0] right_in;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic               accepted;
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_MIX_CLR,
      ST_MIX_VOICE,
      ST_MIX_READ,
      ST_MIX_RD,
      ST_MIX_LOAD,
      ST_MIX_DIV,
      ST_MIX_EMIT
   } state_type;

   // saturate a wide signed sum to a 16-bit sample
   function automatic logic signed [15:0] clamp16(input logic signed [31:0] s);
      logic signed [15:0] r;
      if (s > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (s < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = s[15:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/multi_voice_ring_mixer.sv =====
// ----------------------------------------------------------------------------
// multi_voice_ring_mixer
// Voice slot table with per-voice frame rings and a block mixer.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one beat per command: write a frame, release an
// owner, advance the tick or mix a block. A write passes through ST_WRITE,
// which loads its status beat into the rsp_ result register once that is free;
// release and tick return nothing and finish in the accept cycle.
// A mix returns BLOCK_FRAMES frame beats, the final one marked by last. A mix
// first clears the accumulator memory, then visits each slot and reads n
// frames per contributing voice (n = min(buffered, BLOCK_FRAMES)) through the
// ring memory read port, then per frame reads, loads and emits the sum, with
// 16+clog2(VOICES)+1 divider steps in between when more than one voice
// contributes. One command is in work at a time; req_ready is high only while
// the controller is idle.
// A stalled rsp_ channel holds the result register and the controller waits.
// Reset (synchronous) frees all slots, zeroes the tick and loads register
// defaults; ring contents are undefined until written and need no clearing.
// ----------------------------------------------------------------------------
module multi_voice_ring_mixer #(
   parameter int VOICES       = 4,
   parameter int RING_FRAMES  = 4096,
   parameter int BLOCK_FRAMES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mvrm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mvrm_pkg::rsp_type rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import mvrm_pkg::*;

   localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int IW    = $clog2(RING_FRAMES);
   localparam int AW    = $clog2(VOICES * RING_FRAMES);
   localparam int KW    = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
   localparam int ACC_W = 16 + $clog2(VOICES) + 1;
   localparam int CW    = $clog2(VOICES + 1);
   localparam int RW    = CW + 1;
   localparam int DW    = $clog2(ACC_W + 1);
   localparam int DEPTH = VOICES * RING_FRAMES;
   localparam logic [IW:0] RF_N   = (IW + 1)'(RING_FRAMES);
   localparam logic [KW:0] BF_N   = (KW + 1)'(BLOCK_FRAMES);
   localparam logic [KW:0] BF_END = (KW + 1)'(BLOCK_FRAMES - 1);

   // configuration registers
   logic        enable_ff;
   logic [15:0] prf_ff;
   logic [7:0]  prt_ff;

   // per-voice control state
   logic [15:0]   owner_ff [VOICES];
   logic [IW-1:0] head_ff  [VOICES];
   logic [IW-1:0] tail_ff  [VOICES];
   logic          preroll_ff [VOICES];
   logic [31:0]   lwt_ff   [VOICES];
   logic [31:0]   tick_ff;

   // controller
   state_type state_ff, state_in;
   req_type   req_ff;
   logic [VW:0]   v_ff;
   logic [KW:0]   k_ff;
   logic [KW:0]   n_ff;
   logic [CW-1:0] active_ff;
   logic          rd_vld_ff;
   logic [KW-1:0] rd_k_ff;

   // memories
   logic [31:0]          ring_mem [DEPTH];
   logic [31:0]          ring_q_ff;
   logic [2*ACC_W-1:0]   acc_mem  [BLOCK_FRAMES];
   logic [2*ACC_W-1:0]   acc_q_ff;

   // divider
   logic [ACC_W-1:0] dq_l_ff, dq_r_ff;
   logic [RW-1:0]    rem_l_ff, rem_r_ff;
   logic             sign_l_ff, sign_r_ff;
   logic [DW-1:0]    div_cnt_ff;

   // result register
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   function automatic logic [IW:0] avail_f(input logic [IW-1:0] h, input logic [IW-1:0] t);
      logic [IW:0] r;
      if (h >= t) begin
         r = {1'b0, h} - {1'b0, t};
      end else begin
         r = RF_N - {1'b0, t} + {1'b0, h};
      end
      return r;
   endfunction

   // one restoring-division step on a remainder/dividend pair
   function automatic logic [RW+ACC_W-1:0] div_step(input logic [RW-1:0] rem,
                                                    input logic [ACC_W-1:0] dq,
                                                    input logic [CW-1:0] d);
      logic [RW-1:0] rs;
      logic [RW+ACC_W-1:0] r;
      rs = {rem[RW-2:0], dq[ACC_W-1]};
      if (rs >= {1'b0, d}) begin
         r = {rs - {1'b0, d}, dq[ACC_W-2:0], 1'b1};
      end else begin
         r = {rs, dq[ACC_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- handshake
   logic req_fire, out_free, cfg_wr, rsp_load;
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_load   = out_free && (state_ff == ST_WRITE || state_ff == ST_MIX_EMIT);
   assign csr_pready = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // read back registers
   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[3:2])
         REG_ENABLE:     csr_prdata = {31'd0, enable_ff};
         REG_PR_FRAMES:  csr_prdata = {16'd0, prf_ff};
         REG_PR_TIMEOUT: csr_prdata = {24'd0, prt_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ slot lookup
   logic          hit, free;
   logic [VW-1:0] hit_idx, free_idx, wr_slot;
   logic [IW:0]   wr_avail;
   logic          wr_allow, wr_store;

   always_comb begin
      hit = 1'b0;
      free = 1'b0;
      hit_idx = '0;
      free_idx = '0;
      for (int i = VOICES - 1; i >= 0; i--) begin
         if (owner_ff[i] == req_ff.owner) begin
            hit = 1'b1;
            hit_idx = VW'(i);
         end
         if (owner_ff[i] == 16'd0) begin
            free = 1'b1;
            free_idx = VW'(i);
         end
      end
      wr_slot  = hit ? hit_idx : free_idx;
      wr_avail = hit ? avail_f(head_ff[hit_idx], tail_ff[hit_idx]) : '0;
      wr_allow = enable_ff && (req_ff.owner != 16'd0) && (hit || free);
      wr_store = wr_allow && (wr_avail < RF_N - (IW + 1)'(1));
   end

   // ------------------------------------------------------ current mix voice
   logic [VW-1:0] vi;
   logic [IW:0]   av_cur;
   logic          owned, waitpr, contrib, voices_done;
   logic [KW:0]   n_cur;
   logic [31:0]   since;

   assign vi          = v_ff[VW-1:0];
   assign voices_done = (v_ff == (VW + 1)'(VOICES));
   always_comb begin
      av_cur  = avail_f(head_ff[vi], tail_ff[vi]);
      owned   = owner_ff[vi] != 16'd0;
      since   = tick_ff - lwt_ff[vi];
      waitpr  = preroll_ff[vi] && (32'(av_cur) < 32'(prf_ff)) && (since < 32'(prt_ff));
      contrib = owned && (av_cur != '0) && !waitpr;
      n_cur   = (32'(av_cur) < 32'(BLOCK_FRAMES)) ? (KW + 1)'(av_cur) : BF_N;
   end

   // ------------------------------------------------------------ divider view
   logic [RW+ACC_W-1:0] step_l, step_r;
   logic signed [ACC_W-1:0] acc_l, acc_r, res_l, res_r;
   assign step_l = div_step(rem_l_ff, dq_l_ff, active_ff);
   assign step_r = div_step(rem_r_ff, dq_r_ff, active_ff);
   assign acc_l  = acc_q_ff[ACC_W-1:0];
   assign acc_r  = acc_q_ff[2*ACC_W-1:ACC_W];
   assign res_l  = sign_l_ff ? -$signed(dq_l_ff) : $signed(dq_l_ff);
   assign res_r  = sign_r_ff ? -$signed(dq_r_ff) : $signed(dq_r_ff);

   // ------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_payload.mode == MODE_WRITE) state_in = ST_WRITE;
            else if (req_fire && req_payload.mode == MODE_MIX) state_in = ST_MIX_CLR;
         end
         ST_WRITE:    if (out_free) state_in = ST_IDLE;
         ST_MIX_CLR:  if (k_ff == BF_END) state_in = ST_MIX_VOICE;
         ST_MIX_VOICE: begin
            if (voices_done) state_in = ST_MIX_RD;
            else if (contrib) state_in = ST_MIX_READ;
         end
         ST_MIX_READ: if (k_ff + (KW + 1)'(1) == n_ff) state_in = ST_MIX_VOICE;
         ST_MIX_RD:   state_in = ST_MIX_LOAD;
         ST_MIX_LOAD: state_in = (active_ff > (CW)'(1)) ? ST_MIX_DIV : ST_MIX_EMIT;
         ST_MIX_DIV:  if (div_cnt_ff == DW'(1)) state_in = ST_MIX_EMIT;
         ST_MIX_EMIT: begin
            if (out_free) state_in = (k_ff == BF_END) ? ST_IDLE : ST_MIX_RD;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // ----------------------------------------------------------------- outputs
   logic ring_rd, acc_rd;
   always_comb begin
      req_ready = 1'b0;
      ring_rd   = 1'b0;
      acc_rd    = 1'b0;
      case (state_ff)
         ST_IDLE:     req_ready = 1'b1;
         ST_MIX_READ: begin
            ring_rd = 1'b1;
            acc_rd  = 1'b1;
         end
         ST_MIX_RD:   acc_rd = 1'b1;
         default:     req_ready = 1'b0;
      endcase
   end

   // -------------------------------------------------------------- memories
   logic [AW-1:0] ring_wa, ring_ra;
   assign ring_wa = AW'(wr_slot) * AW'(RING_FRAMES) + AW'(head_ff[wr_slot]);
   assign ring_ra = AW'(vi) * AW'(RING_FRAMES) + AW'(tail_ff[vi]);

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE && out_free && wr_store) begin
         ring_mem[ring_wa] <= {req_ff.right_in, req_ff.left_in};
      end
      if (ring_rd) begin
         ring_q_ff <= ring_mem[ring_ra];
      end
   end

   // clear the block accumulators, or accumulate a frame from the ring into its block position
   always_ff @(posedge clock) begin
      if (state_ff == ST_MIX_CLR) begin
         acc_mem[k_ff[KW-1:0]] <= '0;
      end else if (rd_vld_ff) begin
         acc_mem[rd_k_ff] <= {acc_r + ACC_W'($signed(ring_q_ff[31:16])),
                              acc_l + ACC_W'($signed(ring_q_ff[15:0]))};
      end
      if (acc_rd) begin
         acc_q_ff <= acc_mem[k_ff[KW-1:0]];
      end
   end

   // --------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      rd_k_ff <= k_ff[KW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) req_ff <= req_payload;
         end
         ST_MIX_LOAD: begin
            if (active_ff > CW'(1)) begin
               dq_l_ff   <= acc_l[ACC_W-1] ? ACC_W'(-acc_l) : acc_l;
               dq_r_ff   <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;
               sign_l_ff <= acc_l[ACC_W-1];
               sign_r_ff <= acc_r[ACC_W-1];
            end else begin
               dq_l_ff   <= acc_l;
               dq_r_ff   <= acc_r;
               sign_l_ff <= 1'b0;
               sign_r_ff <= 1'b0;
            end
            rem_l_ff   <= '0;
            rem_r_ff   <= '0;
            div_cnt_ff <= DW'(ACC_W);
         end
         ST_MIX_DIV: begin
            {rem_l_ff, dq_l_ff} <= step_l;
            {rem_r_ff, dq_r_ff} <= step_r;
            div_cnt_ff <= div_cnt_ff - DW'(1);
         end
         default: begin
            div_cnt_ff <= div_cnt_ff;
         end
      endcase
   end

   // ---------------------------------------------------- control state update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         prf_ff       <= PR_FRAMES_RST;
         prt_ff       <= PR_TIMEOUT_RST;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         v_ff         <= '0;
         k_ff         <= '0;
         n_ff         <= '0;
         active_ff    <= '0;
         for (int i = 0; i < VOICES; i++) begin
            owner_ff[i]   <= '0;
            head_ff[i]    <= '0;
            tail_ff[i]    <= '0;
            preroll_ff[i] <= 1'b0;
            lwt_ff[i]     <= '0;
         end
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= ring_rd;

         // load a new result beat or drop the taken one
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // register writes
         if (cfg_wr) begin
            case (csr_paddr[3:2])
               REG_ENABLE:     enable_ff <= csr_pwdata[0];
               REG_PR_FRAMES:  prf_ff    <= csr_pwdata[15:0];
               REG_PR_TIMEOUT: prt_ff    <= csr_pwdata[7:0];
               default:        enable_ff <= enable_ff;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               k_ff      <= '0;
               active_ff <= '0;
               if (req_fire && req_payload.mode == MODE_TICK) begin
                  tick_ff <= tick_ff + 32'd1;
               end
               // drop the owner's slot
               if (req_fire && req_payload.mode == MODE_RELEASE &&
                   req_payload.owner != 16'd0) begin
                  for (int i = 0; i < VOICES; i++) begin
                     if (owner_ff[i] == req_payload.owner) begin
                        owner_ff[i]   <= '0;
                        head_ff[i]    <= '0;
                        tail_ff[i]    <= '0;
                        preroll_ff[i] <= 1'b0;
                        lwt_ff[i]     <= '0;
                     end
                  end
               end
            end
            ST_WRITE: begin
               if (out_free) begin
                  // a free slot already holds an empty ring at index zero,
                  // and a claim always stores its frame
                  if (wr_allow && !hit) begin
                     owner_ff[wr_slot]   <= req_ff.owner;
                     preroll_ff[wr_slot] <= 1'b1;
                     tail_ff[wr_slot]    <= '0;
                  end
                  if (wr_store) begin
                     lwt_ff[wr_slot]  <= tick_ff;
                     head_ff[wr_slot] <= (32'(head_ff[wr_slot]) + 32'd1 >= 32'(RING_FRAMES))
                                         ? '0 : head_ff[wr_slot] + IW'(1);
                  end
                  rsp_ff <= '{kind: KIND_STATUS, accepted: wr_store,
                              left_out: '0, right_out: '0, last: 1'b0};
               end
            end
            ST_MIX_CLR: begin
               k_ff <= k_ff + (KW + 1)'(1);
               v_ff <= '0;
            end
            ST_MIX_VOICE: begin
               k_ff <= '0;
               if (!voices_done) begin
                  if (owned && av_cur == '0) preroll_ff[vi] <= 1'b1;
                  if (contrib) begin
                     preroll_ff[vi] <= 1'b0;
                     n_ff      <= n_cur;
                     active_ff <= active_ff + CW'(1);
                  end else begin
                     v_ff <= v_ff + (VW + 1)'(1);
                  end
               end
            end
            ST_MIX_READ: begin
               // advance the ring tail per frame read
               tail_ff[vi] <= (32'(tail_ff[vi]) + 32'd1 >= 32'(RING_FRAMES))
                              ? '0 : tail_ff[vi] + IW'(1);
               k_ff <= k_ff + (KW + 1)'(1);
               if (k_ff + (KW + 1)'(1) == n_ff) v_ff <= v_ff + (VW + 1)'(1);
            end
            ST_MIX_EMIT: begin
               if (out_free) begin
                  rsp_ff <= '{kind: KIND_FRAME, accepted: 1'b0,
                              left_out: clamp16(32'(res_l)),
                              right_out: clamp16(32'(res_r)),
                              last: (k_ff == BF_END)};
                  k_ff <= k_ff + (KW + 1)'(1);
               end
            end
            default: begin
               k_ff <= k_ff;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // ring data arrives only after a ring read issue
   a_ring_rd: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff) == ST_MIX_READ)
      else $error("ring read data without read issue");

   // the final frame beat is a mixed frame
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> rsp_ff.kind == KIND_FRAME)
      else $error("last flag on a status beat");

   // contributing voice count never exceeds the slot count
   a_active: assert property (@(posedge clock) disable iff (reset)
      32'(active_ff) <= 32'(VOICES))
      else $error("active voice count overflow");

   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");
`endif

endmodule

// ===== dv/tb_multi_voice_ring_mixer.sv =====
// ----------------------------------------------------------------------------
// tb_multi_voice_ring_mixer
// Self-checking bench for the voice ring mixer. A queue of commands feeds a
// bursty driver, a stalling monitor checks every result beat against a
// behavioral predictor of the slot table, the rings and the block mix.
// ----------------------------------------------------------------------------
module tb_multi_voice_ring_mixer;
   import mvrm_pkg::*;

   localparam int NV    = 4;
   localparam int NRING = 4096;
   localparam int NBLK  = 32;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_payload;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   multi_voice_ring_mixer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // mixer model state
   logic        en_q;
   logic [15:0] pr_frames_q;
   logic [7:0]  pr_timeout_q;
   logic [15:0] owner_of [NV];
   int unsigned head_q [NV];
   int unsigned tail_q [NV];
   bit          preroll_q [NV];
   logic [31:0] wtime_q [NV];
   logic [31:0] frame_mem [NV*NRING];
   logic [31:0] ticks_q;

   req_type pending_cmds[$];
   rsp_type expected_beats[$];
   int      errors;
   int      sent_cmds;
   int      driven_cmds;
   bit      stall_hold;   // long receiver hold-off
   bit      send_pause;   // sender pause

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic int unsigned fill_of(int v);
      return (head_q[v] >= tail_q[v]) ? head_q[v] - tail_q[v]
                                      : NRING - tail_q[v] + head_q[v];
   endfunction

   function automatic logic signed [15:0] sat16(int s);
      if (s > 32767) return 16'sh7fff;
      if (s < -32768) return 16'sh8000;
      return s[15:0];
   endfunction

   function automatic bit store_frame(req_type r);
      int slot;
      int spare;
      slot = -1;
      spare = -1;
      if (!en_q || r.owner == 16'd0) return 1'b0;
      for (int v = 0; v < NV; v++) begin
         if (owner_of[v] == r.owner) begin
            slot = v;
            break;
         end
         if (owner_of[v] == 16'd0 && spare < 0) spare = v;
      end
      if (slot < 0) begin
         if (spare < 0) return 1'b0;
         slot = spare;
         head_q[slot] = 0;
         tail_q[slot] = 0;
         preroll_q[slot] = 1'b1;
         wtime_q[slot] = ticks_q;
         owner_of[slot] = r.owner;
      end
      if (fill_of(slot) >= NRING - 1) return 1'b0;
      frame_mem[slot*NRING + head_q[slot]] = {r.right_in, r.left_in};
      head_q[slot] = (head_q[slot] + 1) % NRING;
      wtime_q[slot] = ticks_q;
      return 1'b1;
   endfunction

   task automatic predict_cmd(req_type r);
      rsp_type b;
      int acc [2*NBLK];
      int nact;
      int unsigned avail;
      int unsigned n;
      logic [31:0] f;
      b = '0;
      case (r.mode)
         MODE_WRITE: begin
            b.kind = KIND_STATUS;
            b.accepted = store_frame(r);
            expected_beats.push_back(b);
         end
         MODE_RELEASE: begin
            if (r.owner != 16'd0) begin
               for (int v = 0; v < NV; v++) begin
                  if (owner_of[v] == r.owner) begin
                     owner_of[v] = 16'd0;
                     head_q[v] = 0;
                     tail_q[v] = 0;
                     preroll_q[v] = 1'b0;
                     wtime_q[v] = '0;
                     break;
                  end
               end
            end
         end
         MODE_TICK: ticks_q = ticks_q + 32'd1;
         default: begin
            nact = 0;
            foreach (acc[i]) acc[i] = 0;
            for (int v = 0; v < NV; v++) begin
               if (owner_of[v] == 16'd0) continue;
               avail = fill_of(v);
               if (avail == 0) begin
                  preroll_q[v] = 1'b1;
                  continue;
               end
               if (preroll_q[v]) begin
                  if (avail < pr_frames_q && (ticks_q - wtime_q[v]) < pr_timeout_q)
                     continue;
                  preroll_q[v] = 1'b0;
               end
               n = (avail < NBLK) ? avail : NBLK;
               for (int k = 0; k < n; k++) begin
                  f = frame_mem[v*NRING + tail_q[v]];
                  acc[2*k]   += $signed(f[15:0]);
                  acc[2*k+1] += $signed(f[31:16]);
                  tail_q[v] = (tail_q[v] + 1) % NRING;
               end
               nact++;
            end
            for (int k = 0; k < NBLK; k++) begin
               b = '0;
               b.kind = KIND_FRAME;
               b.left_out  = sat16(nact > 1 ? acc[2*k] / nact : acc[2*k]);
               b.right_out = sat16(nact > 1 ? acc[2*k+1] / nact : acc[2*k+1]);
               b.last = (k == NBLK - 1);
               expected_beats.push_back(b);
            end
         end
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   // ------------------------------------------------------------------------
   // clock, limit
   // ------------------------------------------------------------------------
   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // driver: bursts and gaps, predict at acceptance
   // ------------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_cmd(req_payload);
         sent_cmds++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && sent_cmds != driven_cmds) begin
         // hold the beat until it is taken
      end else if (send_pause || pending_cmds.size() == 0) begin
         req_valid <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else begin
         req_valid <= 1'b1;
         req_payload <= pending_cmds.pop_front();
         driven_cmds++;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: stall pattern, compare beats
   // ------------------------------------------------------------------------
   int stall_phase;

   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset || stall_hold) begin
         rsp_ready <= 1'b0;
      end else if (stall_phase[8]) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat kind", rsp_payload.kind, -1);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_payload.kind !== want.kind)
               report_mismatch("kind", rsp_payload.kind, want.kind);
            if (rsp_payload.accepted !== want.accepted)
               report_mismatch("accepted", rsp_payload.accepted, want.accepted);
            if (rsp_payload.left_out !== want.left_out)
               report_mismatch("left_out", rsp_payload.left_out, want.left_out);
            if (rsp_payload.right_out !== want.right_out)
               report_mismatch("right_out", rsp_payload.right_out, want.right_out);
            if (rsp_payload.last !== want.last)
               report_mismatch("last", rsp_payload.last, want.last);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_ENABLE:     en_q = val[0];
         REG_PR_FRAMES:  pr_frames_q = val[15:0];
         REG_PR_TIMEOUT: pr_timeout_q = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic req_type mk(logic [1:0] m, logic [15:0] o,
                                  logic [15:0] l, logic [15:0] r);
      req_type q;
      q.mode = m;
      q.owner = o;
      q.left_in = l;
      q.right_in = r;
      return q;
   endfunction

   function automatic logic [15:0] pick_owner();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hffff;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // wait until every queued command went out and all results came back
   task automatic drain();
      int guard;
      guard = 0;
      while ((pending_cmds.size() != 0 || req_valid || expected_beats.size() != 0)
             && guard < 2_000_000) begin
         @(posedge clock);
         guard++;
      end
      repeat (400) @(posedge clock);
   endtask

   // well-formed session: writes from a few owners, ticks, a mix, releases
   task automatic queue_session();
      int nw;
      logic [15:0] o;
      nw = $urandom_range(2, 20);
      for (int i = 0; i < nw; i++) begin
         o = ($urandom_range(0, 15) == 0) ? pick_owner() : 16'($urandom_range(1, 5));
         pending_cmds.push_back(mk(MODE_WRITE, o, pick_sample(), pick_sample()));
         if ($urandom_range(0, 5) == 0)
            pending_cmds.push_back(mk(MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom)));
      end
      pending_cmds.push_back(mk(MODE_MIX, 16'($urandom), 16'($urandom), 16'($urandom)));
      if ($urandom_range(0, 2) == 0)
         pending_cmds.push_back(mk(MODE_RELEASE, pick_owner(), 16'($urandom), 16'($urandom)));
   endtask

   initial begin
      errors = 0;
      sent_cmds = 0;
      driven_cmds = 0;
      stall_hold = 1'b0;
      send_pause = 1'b0;
      stall_phase = 0;
      burst_left = 0;
      gap_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      en_q = 1'b0;
      pr_frames_q = PR_FRAMES_RST;
      pr_timeout_q = PR_TIMEOUT_RST;
      ticks_q = '0;
      for (int v = 0; v < NV; v++) begin
         owner_of[v] = '0;
         head_q[v] = 0;
         tail_q[v] = 0;
         preroll_q[v] = 1'b0;
         wtime_q[v] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: disabled write, mix while disabled
      pending_cmds.push_back(mk(MODE_WRITE, 16'd1, 16'h7fff, 16'h8000));
      pending_cmds.push_back(mk(MODE_MIX, 16'd0, 16'd0, 16'd0));
      drain();
      csr_write(REG_ENABLE, 32'd1);
      csr_write(REG_PR_FRAMES, 32'd0);
      // owner zero, full slot table, extremes, dry voice, unknown release
      pending_cmds.push_back(mk(MODE_WRITE, 16'd0, 16'h1234, 16'h4321));
      pending_cmds.push_back(mk(MODE_WRITE, 16'd1, 16'h7fff, 16'h7fff));
      pending_cmds.push_back(mk(MODE_WRITE, 16'd2, 16'h7fff, 16'h8000));
      pending_cmds.push_back(mk(MODE_WRITE, 16'hffff, 16'h8000, 16'h8000));
      pending_cmds.push_back(mk(MODE_WRITE, 16'd4, 16'h8000, 16'h7fff));
      pending_cmds.push_back(mk(MODE_WRITE, 16'd5, 16'h0001, 16'hffff));
      pending_cmds.push_back(mk(MODE_MIX, 16'd0, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_MIX, 16'd0, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_RELEASE, 16'd9, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_RELEASE, 16'd0, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_RELEASE, 16'd2, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_WRITE, 16'd5, 16'h0003, 16'hfffd));
      pending_cmds.push_back(mk(MODE_MIX, 16'd0, 16'd0, 16'd0));
      // free the slot table again
      pending_cmds.push_back(mk(MODE_RELEASE, 16'd1, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_RELEASE, 16'hffff, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_RELEASE, 16'd4, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_RELEASE, 16'd5, 16'd0, 16'd0));
      drain();

      // pre-roll held by frame count, then ended by timeout
      csr_write(REG_PR_FRAMES, 32'hffff);
      csr_write(REG_PR_TIMEOUT, 32'd3);
      pending_cmds.push_back(mk(MODE_WRITE, 16'd7, 16'h0100, 16'h0200));
      pending_cmds.push_back(mk(MODE_MIX, 16'd0, 16'd0, 16'd0));
      for (int i = 0; i < 3; i++)
         pending_cmds.push_back(mk(MODE_TICK, 16'd0, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_MIX, 16'd0, 16'd0, 16'd0));
      drain();

      // one owner buffers a run of frames shorter than a block, a mix drains all of it
      csr_write(REG_PR_TIMEOUT, 32'd0);
      for (int i = 0; i < 20; i++)
         pending_cmds.push_back(mk(MODE_WRITE, 16'd11, 16'($urandom), 16'($urandom)));
      pending_cmds.push_back(mk(MODE_MIX, 16'd0, 16'd0, 16'd0));
      pending_cmds.push_back(mk(MODE_WRITE, 16'd11, 16'h0005, 16'h0006));
      pending_cmds.push_back(mk(MODE_RELEASE, 16'd11, 16'd0, 16'd0));
      // receiver hold-off while the sender keeps offering
      for (int i = 0; i < 10; i++)
         pending_cmds.push_back(mk(MODE_WRITE, 16'd12, pick_sample(), pick_sample()));
      fork
         begin
            stall_hold = 1'b1;
            repeat (600) @(posedge clock);
            stall_hold = 1'b0;
         end
      join_none
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(REG_ENABLE, (ph == 3) ? 32'd0 : 32'd1);
         csr_write(REG_PR_FRAMES, (ph == 1) ? 32'hffff : 32'($urandom_range(0, 24)));
         csr_write(REG_PR_TIMEOUT, (ph == 2) ? 32'hff : 32'($urandom_range(0, 6)));
         for (int s = 0; s < 4; s++) begin
            if ($urandom_range(0, 4) == 0) begin
               pending_cmds.push_back(mk(2'($urandom), pick_owner(),
                                         pick_sample(), pick_sample()));
            end else begin
               queue_session();
            end
         end
         if (ph == 4) begin
            // sender waits for every result before going on
            while (pending_cmds.size() > 4) @(posedge clock);
            send_pause = 1'b1;
            while (req_valid || expected_beats.size() != 0) @(posedge clock);
            send_pause = 1'b0;
         end
         drain();
      end

      if (expected_beats.size() != 0)
         report_mismatch("missing beats", 0, expected_beats.size());
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
